@@ design/rdsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rdsp_pkg
// Shared types and constants for the deadline success probability block.
// ----------------------------------------------------------------------------
package rdsp_pkg;

    localparam int PROB_FRAC_BITS = 32;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

    localparam int DIV_BITS   = 32;
    localparam int DIVISOR_W  = 16;
    localparam int CEIL_W     = DIV_BITS + 1;

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_TIME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PER_STEP = 2'd2;

    localparam logic [1:0] CMD_LOWER = 2'd1;

    typedef enum logic [1:0] {
        TAG_TASK,
        TAG_DEAD,
        TAG_REST
    } t_div_tag;

    typedef struct packed {
        logic                 valid;
        t_div_tag             tag;
        logic [DIVISOR_W-1:0] rem;
        logic [DIV_BITS-1:0]  dvd;
        logic [DIV_BITS-1:0]  quo;
    } t_div_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FEED_DEAD,
        S_FEED_REST,
        S_DIV_WAIT,
        S_BOUND,
        S_POW_MUL,
        S_POW_WR,
        S_ROW,
        S_RD,
        S_MUL,
        S_ACC,
        S_ROW_WR,
        S_BOUND_DONE,
        S_OUT
    } t_state;

endpackage

@@ design/restart_deadline_success_probability.sv @@
// ----------------------------------------------------------------------------
// restart_deadline_success_probability
// Success probability of a restartable task before its deadline.
// ----------------------------------------------------------------------------
// One request at a time. Task, deadline and restart times pass through a
// 32-cell division row, then each bound is computed on the single shared
// multiplier and the one read port of the step table; midpoint mode runs
// both bounds. The input stalls until the result beat is taken.
// ----------------------------------------------------------------------------
module restart_deadline_success_probability
    import rdsp_pkg::*;
#(
    parameter int MAX_STEPS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PROB_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_command,
    input  logic [31:0]          i_task_time,
    input  logic [31:0]          i_deadline_time,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PROB_W-1:0]    o_probability,
    output logic                 o_deadline_clipped
);

    localparam int IW = $clog2(MAX_STEPS);
    localparam logic [CEIL_W-1:0] N_MAX = CEIL_W'(MAX_STEPS - 1);

    logic [DIVISOR_W-1:0] r_step_length;
    logic [31:0]          r_restart_time;
    logic [PROB_W-1:0]    r_decay;

    logic [PROB_W-1:0] r_p_mem [MAX_STEPS];
    logic [PROB_W-1:0] r_f_mem [MAX_STEPS];
    logic [PROB_W-1:0] r_p_rd, r_f_rd;

    t_state            r_state, n_state;
    logic [1:0]        r_cmd, n_cmd;
    logic [31:0]       r_dead, n_dead;
    logic [CEIL_W-1:0] r_m_up, n_m_up;
    logic [IW-1:0]     r_n, n_n;
    logic              r_clip, n_clip;
    logic [CEIL_W-1:0] r_r, n_r;
    logic              r_pass, n_pass;
    logic [CEIL_W-1:0] r_m, n_m;
    logic [IW-1:0]     r_k, n_k;
    logic [IW-1:0]     r_i, n_i;
    logic [PROB_W-1:0] r_pow, n_pow;
    logic [PROB_W-1:0] r_acc, n_acc;
    logic [PROB_W-1:0] r_upper, n_upper;
    logic [PROB_W-1:0] r_res, n_res;
    logic              r_out_valid, n_out_valid;
    logic              r_src_zero;
    logic [2*PROB_W-1:0] r_prod;

    logic [DIVISOR_W-1:0] divisor;
    logic [PROB_W-1:0]    q_eff;
    logic                 div_in_valid;
    t_div_tag             div_in_tag;
    logic [31:0]          div_in_dvd;
    logic                 div_out_valid;
    t_div_tag             div_out_tag;
    logic [CEIL_W-1:0]    div_out_ceil;

    logic [PROB_W-1:0]    mul_a, mul_b, prod_hi;
    logic [CEIL_W-1:0]    m_lo, m_sel;
    logic [CEIL_W+1:0]    idx;
    logic [IW-1:0]        rd_addr;
    logic                 p_we, f_we;
    logic [PROB_W-1:0]    f_wdata;
    logic [PROB_W:0]      acc_sum;
    logic [PROB_W:0]      mid_sum;
    logic [IW:0]          k_inc;

    assign divisor = (r_step_length == '0) ? DIVISOR_W'(1) : r_step_length;
    assign q_eff   = (r_decay > PROB_ONE) ? PROB_ONE : r_decay;
    assign prod_hi = r_prod[PROB_FRAC_BITS +: PROB_W];
    assign m_lo    = (r_m_up == '0) ? '0 : r_m_up - CEIL_W'(1);
    assign k_inc   = {1'b0, r_k} + (IW+1)'(1);
    assign idx     = (CEIL_W+2)'(r_i) - (CEIL_W+2)'(r_k) - (CEIL_W+2)'(r_r)
                   - (CEIL_W+2)'(1);
    assign rd_addr = (!idx[CEIL_W+1] && idx != '0) ? idx[IW-1:0] : '0;
    assign acc_sum = {1'b0, r_acc} + {1'b0, prod_hi};
    assign mid_sum = {1'b0, r_upper} + {1'b0, r_acc};

    rdsp_div_chain u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_divisor  (divisor),
        .i_valid    (div_in_valid),
        .i_tag      (div_in_tag),
        .i_dividend (div_in_dvd),
        .o_valid    (div_out_valid),
        .o_tag      (div_out_tag),
        .o_ceil     (div_out_ceil)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_length  <= DIVISOR_W'(1);
            r_restart_time <= '0;
            r_decay        <= PROB_ONE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STEP_LENGTH:    r_step_length  <= i_cfg_data[DIVISOR_W-1:0];
                CFG_RESTART_TIME:   r_restart_time <= i_cfg_data[31:0];
                CFG_DECAY_PER_STEP: r_decay        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_p_mem[r_i] <= r_acc;
        end
        if (f_we) begin
            r_f_mem[r_k] <= f_wdata;
        end
        r_p_rd <= r_p_mem[rd_addr];
        r_f_rd <= r_f_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_dead      = r_dead;
        n_m_up      = r_m_up;
        n_n         = r_n;
        n_clip      = r_clip;
        n_r         = r_r;
        n_pass      = r_pass;
        n_m         = r_m;
        n_k         = r_k;
        n_i         = r_i;
        n_pow       = r_pow;
        n_acc       = r_acc;
        n_upper     = r_upper;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        div_in_valid = 1'b0;
        div_in_tag   = TAG_TASK;
        div_in_dvd   = i_task_time;
        mul_a   = r_f_rd;
        mul_b   = r_src_zero ? '0 : r_p_rd;
        p_we    = 1'b0;
        f_we    = 1'b0;
        f_wdata = r_pow - prod_hi;
        m_sel   = (r_cmd == CMD_LOWER || r_pass) ? m_lo : r_m_up;

        if (div_out_valid) begin
            unique case (div_out_tag)
                TAG_TASK: n_m_up = div_out_ceil;
                TAG_DEAD: begin
                    n_clip = div_out_ceil > N_MAX;
                    n_n    = n_clip ? N_MAX[IW-1:0] : div_out_ceil[IW-1:0];
                end
                TAG_REST: n_r = div_out_ceil;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    div_in_valid = 1'b1;
                    n_cmd   = i_command;
                    n_dead  = i_deadline_time;
                    n_pass  = 1'b0;
                    n_state = S_FEED_DEAD;
                end
            end
            S_FEED_DEAD: begin
                div_in_valid = 1'b1;
                div_in_tag   = TAG_DEAD;
                div_in_dvd   = r_dead;
                n_state      = S_FEED_REST;
            end
            S_FEED_REST: begin
                div_in_valid = 1'b1;
                div_in_tag   = TAG_REST;
                div_in_dvd   = r_restart_time;
                n_state      = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_out_valid && div_out_tag == TAG_REST) begin
                    n_state = S_BOUND;
                end
            end
            S_BOUND: begin
                n_m   = m_sel;
                n_k   = '0;
                n_pow = PROB_ONE;
                n_i   = m_sel[IW-1:0];
                if (m_sel > CEIL_W'(r_n)) begin
                    n_acc   = '0;
                    n_state = S_BOUND_DONE;
                end else if (m_sel == '0) begin
                    n_state = S_ROW;
                end else begin
                    n_state = S_POW_MUL;
                end
            end
            S_POW_MUL: begin
                mul_a   = r_pow;
                mul_b   = q_eff;
                n_state = S_POW_WR;
            end
            S_POW_WR: begin
                f_we  = 1'b1;
                n_pow = prod_hi;
                if (CEIL_W'(k_inc) == r_m) begin
                    n_state = S_ROW;
                end else begin
                    n_k     = k_inc[IW-1:0];
                    n_state = S_POW_MUL;
                end
            end
            S_ROW: begin
                n_acc   = r_pow;
                n_k     = '0;
                n_state = (r_m == '0) ? S_ROW_WR : S_RD;
            end
            S_RD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc = (acc_sum > {1'b0, PROB_ONE}) ? PROB_ONE : acc_sum[PROB_W-1:0];
                if (CEIL_W'(k_inc) == r_m) begin
                    n_state = S_ROW_WR;
                end else begin
                    n_k     = k_inc[IW-1:0];
                    n_state = S_RD;
                end
            end
            S_ROW_WR: begin
                p_we = 1'b1;
                if (r_i == r_n) begin
                    n_state = S_BOUND_DONE;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_ROW;
                end
            end
            S_BOUND_DONE: begin
                if (r_cmd[1] && !r_pass) begin
                    n_upper = r_acc;
                    n_pass  = 1'b1;
                    n_state = S_BOUND;
                end else begin
                    n_res       = r_cmd[1] ? mid_sum[PROB_W:1] : r_acc;
                    n_out_valid = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pass      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pass      <= n_pass;
        end
        r_cmd      <= n_cmd;
        r_dead     <= n_dead;
        r_m_up     <= n_m_up;
        r_n        <= n_n;
        r_clip     <= n_clip;
        r_r        <= n_r;
        r_m        <= n_m;
        r_k        <= n_k;
        r_i        <= n_i;
        r_pow      <= n_pow;
        r_acc      <= n_acc;
        r_upper    <= n_upper;
        r_res      <= n_res;
        r_src_zero <= rd_addr < r_m[IW-1:0];
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_probability      = r_res;
    assign o_deadline_clipped = r_clip;

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result beat is pending");

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid))
        else $error("block not busy after accepting a beat");

    a_acc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW_WR) |-> (r_acc <= PROB_ONE))
        else $error("step probability above one");

endmodule

@@ design/rdsp_div_cell.sv @@
// ----------------------------------------------------------------------------
// rdsp_div_cell
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module rdsp_div_cell
    import rdsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [DIVISOR_W-1:0] i_divisor,
    input  t_div_beat            i_beat,
    output t_div_beat            o_beat
);

    t_div_beat               r_beat;
    t_div_beat               n_beat;
    logic [DIVISOR_W:0]      trial;
    logic                    fits;

    always_comb begin
        trial  = {i_beat.rem, i_beat.dvd[DIV_BITS-1]};
        fits   = trial >= {1'b0, i_divisor};
        n_beat = i_beat;
        n_beat.dvd = {i_beat.dvd[DIV_BITS-2:0], 1'b0};
        n_beat.quo = {i_beat.quo[DIV_BITS-2:0], fits};
        if (fits) begin
            n_beat.rem = DIVISOR_W'(trial - {1'b0, i_divisor});
        end else begin
            n_beat.rem = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.tag <= n_beat.tag;
        r_beat.rem <= n_beat.rem;
        r_beat.dvd <= n_beat.dvd;
        r_beat.quo <= n_beat.quo;
    end

    assign o_beat = r_beat;

endmodule

@@ design/rdsp_div_chain.sv @@
// ----------------------------------------------------------------------------
// rdsp_div_chain
// Row of division cells giving the ceiling of a dividend over the step length.
// ----------------------------------------------------------------------------
module rdsp_div_chain
    import rdsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [DIVISOR_W-1:0] i_divisor,
    input  logic                 i_valid,
    input  t_div_tag             i_tag,
    input  logic [DIV_BITS-1:0]  i_dividend,
    output logic                 o_valid,
    output t_div_tag             o_tag,
    output logic [CEIL_W-1:0]    o_ceil
);

    t_div_beat links [DIV_BITS+1];

    always_comb begin
        links[0].valid = i_valid;
        links[0].tag   = i_tag;
        links[0].rem   = '0;
        links[0].dvd   = i_dividend;
        links[0].quo   = '0;
    end

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_cell
        rdsp_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (i_divisor),
            .i_beat    (links[g]),
            .o_beat    (links[g+1])
        );
    end

    assign o_valid = links[DIV_BITS].valid;
    assign o_tag   = links[DIV_BITS].tag;
    assign o_ceil  = {1'b0, links[DIV_BITS].quo}
                   + CEIL_W'(links[DIV_BITS].rem != '0);

endmodule

@@ tb/restart_deadline_success_probability_test.sv @@
// ----------------------------------------------------------------------------
// restart_deadline_success_probability_test
// Drives deadline requests through the block under several register settings
// and scores every result beat against a bit-exact fixed point predictor.
// ----------------------------------------------------------------------------
module restart_deadline_success_probability_test;
    import rdsp_pkg::*;

    localparam int       TABLE_DEPTH = 1024;
    localparam int       CYCLE_LIMIT = 4000000;
    localparam bit [1:0] CMD_UPPER   = 2'd0;
    localparam bit [1:0] CMD_MID     = 2'd2;
    localparam bit [1:0] CMD_MID_ALT = 2'd3;
    localparam logic [63:0] FX_ONE   = 64'd1 << PROB_FRAC_BITS;

    typedef struct {
        logic [PROB_W-1:0] probability;
        logic              clipped;
    } t_outcome;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PROB_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_command;
    logic [31:0]          i_task_time;
    logic [31:0]          i_deadline_time;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [PROB_W-1:0]    o_probability;
    logic                 o_deadline_clipped;

    t_outcome    pending_outcomes[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          quiet = 0;
    int          stall_burst = 0;
    logic [15:0] step_len_reg;
    logic [31:0] restart_reg;
    logic [32:0] decay_reg;
    logic [63:0] step_prob[TABLE_DEPTH];
    logic [63:0] fail_term[TABLE_DEPTH];

    restart_deadline_success_probability i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_task_time        (i_task_time),
        .i_deadline_time    (i_deadline_time),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_probability      (o_probability),
        .o_deadline_clipped (o_deadline_clipped)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [63:0] fx_product(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[PROB_FRAC_BITS +: 64];
    endfunction

    function automatic logic [63:0] steps_of(logic [63:0] t, logic [63:0] len);
        return t / len + ((t % len) != 0 ? 64'd1 : 64'd0);
    endfunction

    function automatic logic [63:0] bound_probability(logic [63:0] m, logic [63:0] n,
                                                      logic [63:0] r, logic [63:0] q);
        logic [63:0] pw;
        logic [63:0] nx;
        logic [63:0] acc;
        logic [63:0] src;
        longint      idx;
        if (m > n) return 64'd0;
        foreach (step_prob[j]) step_prob[j] = 64'd0;
        pw = FX_ONE;
        for (int k = 0; k < m; k++) begin
            nx = fx_product(pw, q);
            fail_term[k] = pw - nx;
            pw = nx;
        end
        for (int i = int'(m); i <= int'(n); i++) begin
            acc = pw;
            for (int k = 0; k < m; k++) begin
                idx = longint'(i) - longint'(k) - longint'(r) - 1;
                src = idx > 0 ? step_prob[idx] : step_prob[0];
                acc = acc + fx_product(fail_term[k], src);
                if (acc > FX_ONE) acc = FX_ONE;
            end
            step_prob[i] = acc;
        end
        return step_prob[n];
    endfunction

    function automatic t_outcome success_outcome(logic [1:0] cmd, logic [31:0] task_t,
                                                 logic [31:0] dead_t);
        t_outcome    o;
        logic [63:0] len;
        logic [63:0] q;
        logic [63:0] m_up;
        logic [63:0] m_lo;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] up;
        logic [63:0] res;
        len  = step_len_reg != 0 ? 64'(step_len_reg) : 64'd1;
        q    = 64'(decay_reg) > FX_ONE ? FX_ONE : 64'(decay_reg);
        m_up = steps_of(64'(task_t), len);
        m_lo = m_up > 0 ? m_up - 64'd1 : 64'd0;
        n    = steps_of(64'(dead_t), len);
        r    = steps_of(64'(restart_reg), len);
        o.clipped = 1'b0;
        if (n > 64'(TABLE_DEPTH - 1)) begin
            n = 64'(TABLE_DEPTH - 1);
            o.clipped = 1'b1;
        end
        if (cmd[1]) begin
            up  = bound_probability(m_up, n, r, q);
            res = (up + bound_probability(m_lo, n, r, q)) >> 1;
        end else if (cmd == CMD_LOWER) begin
            res = bound_probability(m_lo, n, r, q);
        end else begin
            res = bound_probability(m_up, n, r, q);
        end
        o.probability = res[PROB_W-1:0];
        return o;
    endfunction

    always @(negedge i_clk) begin
        if (quiet) begin
            i_out_stall = 1'b0;
        end else if (stall_burst > 0) begin
            i_out_stall = 1'b1;
            stall_burst--;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall = 1'b1;
            stall_burst = $urandom_range(0, 4);
        end else begin
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected beat prob=%h clipped=%b", $time,
                         o_probability, o_deadline_clipped);
                error_count++;
            end else begin
                exp_o = pending_outcomes.pop_front();
                if (o_probability !== exp_o.probability) begin
                    $display("%0t: probability expected %h actual %h", $time,
                             exp_o.probability, o_probability);
                    error_count++;
                end
                if (o_deadline_clipped !== exp_o.clipped) begin
                    $display("%0t: deadline_clipped expected %b actual %b", $time,
                             exp_o.clipped, o_deadline_clipped);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(logic [1:0] cmd, logic [31:0] task_t, logic [31:0] dead_t);
        if (!quiet && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        i_command       = cmd;
        i_task_time     = task_t;
        i_deadline_time = dead_t;
        i_in_valid      = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_outcomes.push_back(success_outcome(cmd, task_t, dead_t));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (48) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PROB_W-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        if (idx == CFG_STEP_LENGTH) step_len_reg = data[15:0];
        else if (idx == CFG_RESTART_TIME) restart_reg = data[31:0];
        else if (idx == CFG_DECAY_PER_STEP) decay_reg = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic test_directed();
        send_request(CMD_UPPER, 32'd3, 32'd5);
        send_request(CMD_MID, 32'd0, 32'd0);
        drain_results();
        write_reg(CFG_DECAY_PER_STEP, 33'h0_C000_0000);
        write_reg(CFG_RESTART_TIME, 33'd2);
        send_request(CMD_UPPER, 32'd0, 32'd0);
        send_request(CMD_LOWER, 32'd0, 32'd0);
        send_request(CMD_LOWER, 32'd1, 32'd1);
        send_request(CMD_UPPER, 32'd4, 32'd20);
        send_request(CMD_LOWER, 32'd4, 32'd20);
        send_request(CMD_MID, 32'd5, 32'd20);
        send_request(CMD_MID_ALT, 32'd5, 32'd20);
        send_request(CMD_UPPER, 32'd10, 32'd4);
        send_request(CMD_LOWER, 32'd5, 32'd4);
        send_request(CMD_UPPER, 32'd3, 32'hFFFF_FFFF);
        send_request(CMD_MID_ALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_UPPER, 32'd1023, 32'd1023);
        send_request(CMD_UPPER, 32'd1024, 32'd1023);
        send_request(CMD_LOWER, 32'd1024, 32'd1024);
        drain_results();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_STEP_LENGTH, 33'd0);
        write_reg(CFG_RESTART_TIME, 33'h0_FFFF_FFFF);
        write_reg(CFG_DECAY_PER_STEP, 33'h1_FFFF_FFFF);
        send_request(CMD_UPPER, 32'd6, 32'd30);
        send_request(CMD_MID, 32'd7, 32'd12);
        drain_results();
        write_reg(CFG_DECAY_PER_STEP, 33'd0);
        write_reg(CFG_RESTART_TIME, 33'd0);
        send_request(CMD_UPPER, 32'd3, 32'd9);
        send_request(CMD_LOWER, 32'd1, 32'd9);
        drain_results();
        write_reg(CFG_STEP_LENGTH, 33'h1_5555_FFFF);
        write_reg(CFG_DECAY_PER_STEP, 33'h1_0000_0000);
        write_reg(CFG_RESTART_TIME, 33'd70000);
        send_request(CMD_MID_ALT, 32'h0010_0000, 32'h0080_0000);
        send_request(CMD_LOWER, 32'hFFFF_FFFF, 32'h7FFF_0000);
        send_request(CMD_UPPER, 32'd1, 32'd65536);
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [31:0] len;
        for (int phase = 0; phase < 4; phase++) begin
            len = $urandom_range(1, 8);
            write_reg(CFG_STEP_LENGTH, 33'(len));
            write_reg(CFG_RESTART_TIME, 33'($urandom_range(0, 6 * len)));
            write_reg(CFG_DECAY_PER_STEP, 33'($urandom_range(32'h8000_0000, 32'hFFFF_FFFF)));
            for (int j = 0; j < 25; j++) begin
                if (phase == 3 && j >= 12) quiet = 1;
                if ($urandom_range(0, 4) == 0)
                    send_request(2'($urandom), $urandom | 32'h8000_0000, $urandom);
                else
                    send_request(2'($urandom), $urandom_range(0, 25 * len),
                                 $urandom_range(0, 60 * len));
            end
            drain_results();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = CFG_STEP_LENGTH;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_command       = CMD_UPPER;
        i_task_time     = '0;
        i_deadline_time = '0;
        i_out_stall     = 1'b0;
        step_len_reg    = 16'd1;
        restart_reg     = 32'd0;
        decay_reg       = PROB_ONE;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_register_extremes();
        test_random_traffic();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
